>>> hw/rtl/bmsh_pkg.sv
// ----------------------------------------------------------------------------
// bmsh_pkg
// Types and constants of the binned mean / std dev histogram unit.
// ----------------------------------------------------------------------------
package bmsh_pkg;

  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS     = 2'd2;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_DUMP = 1'b1;

  typedef struct packed {
    logic               action;
    logic        [15:0] distance;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic signed [15:0] bin_mean;
    logic        [15:0] bin_std_dev;
    logic        [31:0] bin_count;
    logic               last;
  } out_item_t;

  // shared divider operation
  typedef enum logic [1:0] {
    DOP_BIN  = 2'd0,
    DOP_MEAN = 2'd1,
    DOP_VAR  = 2'd2
  } div_op_e;

  typedef struct packed {
    logic  start;
    logic  [127:0] num;
    logic  [63:0]  den;
    logic  [7:0]   steps;
  } div_req_t;

endpackage

>>> hw/rtl/bmsh_divider.sv
// ----------------------------------------------------------------------------
// bmsh_divider
// Restoring divider, one quotient bit per cycle, MSB aligned numerator.
// ----------------------------------------------------------------------------
module bmsh_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmsh_pkg::div_req_t req_i,
  output logic             busy_o,
  output logic [63:0]      quot_o
);
  import bmsh_pkg::*;

  logic [127:0] num_q, num_d;
  logic [63:0]  rem_q, rem_d, quot_q, quot_d, den_q, den_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic [64:0]  trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; quot_d = quot_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, num_q[127]};
    if (req_i.start) begin
      // numerator arrives left-aligned; steps gives number of bits
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[126:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 64'(trial - {1'b0, den_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[63:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 8'd1;
      if (cnt_q == 8'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quot_q <= quot_d; den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

`ifndef NO_ASSERTIONS
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start |-> cnt_q != 8'd0) else $error("busy with zero count");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == 8'd1 |=> !busy_q) else $error("divider overrun");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && req_i.steps != 8'd0 |=> busy_q) else $error("divider not started");
`endif
endmodule

>>> hw/rtl/bmsh_sqrt.sv
// ----------------------------------------------------------------------------
// bmsh_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module bmsh_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  import bmsh_pkg::*;

  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial_rem, trial_sub;

  always_comb begin
    x_d = x_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q; busy_d = busy_q;
    trial_rem = {rem_q[31:0], x_q[63:62]};
    trial_sub = {root_q, 2'b01};
    if (start_i) begin
      x_d = x_i; rem_d = '0; root_d = '0; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[61:0], 2'b00};
      if (trial_rem >= trial_sub) begin
        rem_d  = trial_rem - trial_sub;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = trial_rem;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; rem_q <= rem_d; root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

`ifndef NO_ASSERTIONS
  a_sq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == 6'd32) else $error("sqrt not started");
  a_sq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == 6'd1 |=> !busy_q) else $error("sqrt overrun");
  a_sq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("sqrt busy at zero");
`endif
endmodule

>>> hw/rtl/binned_mean_stddev_histogram_unit.sv
// ----------------------------------------------------------------------------
// binned_mean_stddev_histogram_unit
// Histogram of samples by distance; each bin keeps count, sum and sum of
// squares, reported as count, mean and sample std dev on a dump.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o  | in_item_t
//  out     | output    | out_valid_o/out_ready_i| out_item_t
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Add: a binned sample takes the shared serial divider (23 steps for the bin
// number) plus a read and a write of the bin store; a dropped one is not stored.
// Dump: per bin with two or more samples: 64 divider steps for the mean,
// three 64-step serial multiplies, 128 for the variance, 32 sqrt steps; only the mean with one, neither when empty.
// After reset a clearing pass over all 64 bins zeroes the store; no input
// transaction is taken meanwhile. A stalled output holds the sequencer.
module binned_mean_stddev_histogram_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bmsh_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bmsh_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [bmsh_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bmsh_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bmsh_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_BDIV   = 14'b00000000000100,
    S_BRD    = 14'b00000000001000,
    S_BWR    = 14'b00000000010000,
    S_DRD    = 14'b00000000100000,
    S_DLAT   = 14'b00000001000000,
    S_MDIV   = 14'b00000010000000,
    S_MUL    = 14'b00000100000000,
    S_VDIV   = 14'b00001000000000,
    S_SQRT   = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_MSTART = 14'b01000000000000,
    S_VSTART = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] min_q, max_q;
  logic [6:0]  bins_q;
  logic [6:0]  nb;

  // bin store
  logic [31:0] cnt_mem [NUM_BINS];
  logic [47:0] sum_mem [NUM_BINS];
  logic [63:0] sq_mem  [NUM_BINS];
  logic [31:0] rd_cnt;
  logic [47:0] rd_sum;
  logic [63:0] rd_sq;
  logic        we;
  logic [BIN_W-1:0] wr_addr, rd_addr;
  logic [31:0] wr_cnt;
  logic [47:0] wr_sum;
  logic [63:0] wr_sq;

  logic [BIN_W-1:0] bin_q, bin_d;
  logic signed [15:0] val_q, val_d;
  logic [31:0] n_q, n_d;
  logic [47:0] sum_q, sum_d;
  logic [63:0] sq_q, sq_d;
  logic signed [15:0] mean_q, mean_d;
  logic [15:0] sd_q, sd_d;
  // serial shift-add multiplier accumulators
  logic [127:0] acc_q, acc_d;
  logic [63:0]  mcand_q, mcand_d;
  logic [63:0]  mplier_q, mplier_d;
  logic [6:0]   mcnt_q, mcnt_d;
  logic [1:0]   mphase_q, mphase_d;
  logic [127:0] prod_a_q, prod_a_d;
  logic [63:0]  den_q, den_d;

  logic        ovalid_q, ovalid_d;
  out_item_t   odata_q, odata_d;

  div_req_t    dreq;
  logic        dbusy;
  logic [63:0] dquot;
  logic        sq_start, sq_busy;
  logic [63:0] sq_x;
  logic [31:0] sq_root;

  logic [15:0] span, offs;
  logic [22:0] prod_bin;
  logic [47:0] mag;
  logic        neg;
  logic [127:0] diff;
  logic        take;

  assign nb = (bins_q == 7'd0) ? 7'd1 : ((bins_q > 7'(NUM_BINS)) ? 7'(NUM_BINS) : bins_q);
  assign span = max_q - min_q;
  assign offs = in_data_i.distance - min_q;
  assign neg  = sum_q[47];
  assign mag  = neg ? 48'(-sum_q) : sum_q;
  assign diff = prod_a_q - acc_q;

  bmsh_divider u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(dreq),
    .busy_o(dbusy), .quot_o(dquot)
  );

  bmsh_sqrt u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start), .x_i(sq_x),
    .busy_o(sq_busy), .root_o(sq_root)
  );

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign take       = in_valid_i && in_ready_o;
  assign prod_bin   = 23'(offs) * 23'(nb);

  always_comb begin
    state_d = state_q; bin_d = bin_q; val_d = val_q; n_d = n_q; sum_d = sum_q;
    sq_d = sq_q; mean_d = mean_q; sd_d = sd_q; acc_d = acc_q; mcand_d = mcand_q;
    mplier_d = mplier_q; mcnt_d = mcnt_q; mphase_d = mphase_q;
    prod_a_d = prod_a_q; den_d = den_q; ovalid_d = ovalid_q; odata_d = odata_q;
    dreq = '0; sq_start = 1'b0; sq_x = '0;
    we = 1'b0; wr_addr = bin_q; wr_cnt = '0; wr_sum = '0; wr_sq = '0;
    rd_addr = bin_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        bin_d = bin_q + 6'd1;
        if (bin_q == 6'(NUM_BINS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (in_data_i.action == ACT_DUMP) begin
            bin_d = '0; state_d = S_DRD;
          end else if (max_q > min_q && in_data_i.distance >= min_q
                       && in_data_i.distance <= max_q) begin
            val_d = in_data_i.sample_value;
            dreq.start = 1'b1;
            dreq.num   = {prod_bin, 105'd0};
            dreq.den   = 64'(span);
            dreq.steps = 8'd23;
            state_d = S_BDIV;
          end
        end
      end
      S_BDIV: if (!dbusy) begin
        bin_d = (dquot > 64'(nb - 7'd1)) ? 6'(nb - 7'd1) : dquot[BIN_W-1:0];
        state_d = S_BRD;
      end
      S_BRD: state_d = S_BWR;
      S_BWR: begin
        if (rd_cnt != 32'hFFFF_FFFF) begin
          we = 1'b1;
          wr_cnt = rd_cnt + 32'd1;
          wr_sum = rd_sum + 48'(val_q);
          wr_sq  = rd_sq + 64'(32'(val_q) * 32'(val_q));
        end
        state_d = S_IDLE;
      end
      S_DRD: state_d = S_DLAT;
      S_DLAT: begin
        n_d = rd_cnt; sum_d = rd_sum; sq_d = rd_sq;
        state_d = S_MSTART;
      end
      S_MSTART: begin
        if (n_q == 32'd0) begin
          mean_d = '0; sd_d = '0; state_d = S_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = {16'd0, mag, 64'd0};
          dreq.den   = 64'(n_q);
          dreq.steps = 8'd64;
          state_d = S_MDIV;
        end
      end
      S_MDIV: if (!dbusy) begin
        mean_d = neg ? 16'(-dquot) : dquot[15:0];
        if (n_q < 32'd2) begin
          sd_d = '0; state_d = S_OUT;
        end else begin
          // phase 0: n*sumsq, phase 1: |sum|^2, phase 2: n*(n-1)
          acc_d = '0; mcand_d = sq_q; mplier_d = 64'(n_q);
          mcnt_d = 7'd64; mphase_d = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mcnt_q != 7'd0) begin
          if (mplier_q[63]) acc_d = {acc_q[126:0], 1'b0} + 128'(mcand_q);
          else acc_d = {acc_q[126:0], 1'b0};
          mplier_d = {mplier_q[62:0], 1'b0};
          mcnt_d = mcnt_q - 7'd1;
        end else begin
          mcnt_d = 7'd64;
          acc_d = '0;
          case (mphase_q)
            2'd0: begin
              prod_a_d = acc_q; mcand_d = 64'(mag); mplier_d = 64'(mag);
              mphase_d = 2'd1;
            end
            2'd1: begin
              prod_a_d = diff; den_d = '0;
              mcand_d = 64'(n_q); mplier_d = 64'(n_q - 32'd1);
              mphase_d = 2'd2;
              if (prod_a_q < acc_q) begin
                sd_d = '0; state_d = S_OUT;
              end
            end
            default: begin
              den_d = acc_q[63:0];
              state_d = S_VSTART;
            end
          endcase
        end
      end
      S_VSTART: begin
        dreq.start = 1'b1;
        dreq.num   = prod_a_q;
        dreq.den   = den_q;
        dreq.steps = 8'd128;
        state_d = S_VDIV;
      end
      S_VDIV: if (!dbusy) begin
        sq_start = 1'b1; sq_x = dquot;
        state_d = S_SQRT;
      end
      S_SQRT: if (!sq_busy) begin
        sd_d = sq_root[15:0];
        state_d = S_OUT;
      end
      S_OUT: if (!ovalid_q || out_ready_i) begin
        ovalid_d = 1'b1;
        odata_d.bin_index   = bin_q;
        odata_d.bin_mean    = mean_q;
        odata_d.bin_std_dev = sd_q;
        odata_d.bin_count   = n_q;
        odata_d.last        = (7'(bin_q) == nb - 7'd1);
        if (7'(bin_q) == nb - 7'd1) state_d = S_IDLE;
        else begin
          bin_d = bin_q + 6'd1; state_d = S_DRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[wr_addr] <= wr_cnt;
      sum_mem[wr_addr] <= wr_sum;
      sq_mem[wr_addr]  <= wr_sq;
    end
    rd_cnt <= cnt_mem[rd_addr];
    rd_sum <= sum_mem[rd_addr];
    rd_sq  <= sq_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      bin_q    <= '0;
      ovalid_q <= 1'b0;
      min_q    <= 16'd0;
      max_q    <= 16'hFFFF;
      bins_q   <= 7'd64;
      mcnt_q   <= '0;
      mphase_q <= '0;
    end else begin
      state_q  <= state_d;
      bin_q    <= bin_d;
      ovalid_q <= ovalid_d;
      mcnt_q   <= mcnt_d;
      mphase_q <= mphase_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_DIST: min_q  <= cfg_data_i;
          REG_MAX_DIST: max_q  <= cfg_data_i;
          REG_BINS:     bins_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; n_q <= n_d; sum_q <= sum_d; sq_q <= sq_d; mean_q <= mean_d;
    sd_q <= sd_d; acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
    prod_a_q <= prod_a_d; den_q <= den_d; odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE && !dbusy && !sq_busy) else $error("ready while busy");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && state_d == S_IDLE |=> ovalid_q && odata_q.last)
    else $error("dump ended without last");
`endif
endmodule

>>> tb/bmsh_checker.sv
// ----------------------------------------------------------------------------
// bmsh_checker
// Watches the configuration, input and output channels of the histogram unit.
// Keeps its own bin store, predicts every dump and compares each output
// transaction, field by field, with the oldest predicted bin report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsh_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  bmsh_pkg::in_item_t                  in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  bmsh_pkg::out_item_t                 out_data_i,
  input  logic                                cfg_we_i,
  input  logic [bmsh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bmsh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                  err_count_o,
  output int                                  pending_o,
  output int                                  reports_seen_o
);
  import bmsh_pkg::*;

  logic [15:0]        lo_dist, hi_dist;
  logic [6:0]         bins_reg;
  logic [31:0]        cnt_q [NUM_BINS];
  logic signed [47:0] sum_q [NUM_BINS];
  logic [63:0]        sq_q  [NUM_BINS];
  out_item_t          bin_reports_q [$];

  assign pending_o = bin_reports_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    err_count_o++;
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] std_dev_est(input logic [31:0] n,
                                              input logic signed [47:0] s,
                                              input logic [63:0] sq);
    logic [127:0] a, b, q;
    logic [63:0]  mag;
    if (n < 2) return '0;
    a   = 128'(n) * 128'(sq);
    mag = (s < 0) ? 64'(-64'(s)) : 64'(s);
    b   = 128'(mag) * 128'(mag);
    if (a < b) return '0;
    q = (a - b) / (128'(n) * 128'(n - 1));
    return 16'(root_floor(q[63:0]));
  endfunction

  function automatic int eff_bins();
    if (bins_reg == 0) return 1;
    if (bins_reg > NUM_BINS) return NUM_BINS;
    return int'(bins_reg);
  endfunction

  // add: bin the sample; dump: queue one report per bin in use
  task automatic apply_item(input in_item_t it);
    int          nb;
    logic [31:0] bin;
    longint      mean;
    out_item_t   r;
    nb = eff_bins();
    if (it.action == ACT_ADD) begin
      if (hi_dist <= lo_dist || it.distance < lo_dist || it.distance > hi_dist) return;
      bin = (32'(it.distance - lo_dist) * 32'(nb)) / 32'(hi_dist - lo_dist);
      if (bin > nb - 1) bin = nb - 1;
      if (cnt_q[bin] == 32'hFFFF_FFFF) return;
      cnt_q[bin]++;
      sum_q[bin] = sum_q[bin] + 48'(it.sample_value);
      sq_q[bin]  = sq_q[bin] + 64'(longint'(it.sample_value) * longint'(it.sample_value));
    end else begin
      for (int i = 0; i < nb; i++) begin
        mean = (cnt_q[i] > 0) ? longint'(sum_q[i]) / longint'({32'h0, cnt_q[i]}) : 0;
        r.bin_index   = BIN_W'(i);
        r.bin_mean    = 16'(mean);
        r.bin_std_dev = std_dev_est(cnt_q[i], sum_q[i], sq_q[i]);
        r.bin_count   = cnt_q[i];
        r.last        = (i == nb - 1);
        bin_reports_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      lo_dist  <= 16'h0000;
      hi_dist  <= 16'hFFFF;
      bins_reg <= 7'd64;
      for (int i = 0; i < NUM_BINS; i++) begin
        cnt_q[i] = '0;
        sum_q[i] = '0;
        sq_q[i]  = '0;
      end
      bin_reports_q.delete();
      err_count_o    <= 0;
      reports_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        reports_seen_o <= reports_seen_o + 1;
        if (bin_reports_q.size() == 0) begin
          report("unexpected bin report, index", 64'(out_data_i.bin_index), 0);
        end else begin
          e = bin_reports_q.pop_front();
          if (out_data_i.bin_index !== e.bin_index)
            report("bin_index", 64'(out_data_i.bin_index), 64'(e.bin_index));
          if (out_data_i.bin_mean !== e.bin_mean)
            report("bin_mean", 64'(out_data_i.bin_mean), 64'(e.bin_mean));
          if (out_data_i.bin_std_dev !== e.bin_std_dev)
            report("bin_std_dev", 64'(out_data_i.bin_std_dev), 64'(e.bin_std_dev));
          if (out_data_i.bin_count !== e.bin_count)
            report("bin_count", 64'(out_data_i.bin_count), 64'(e.bin_count));
          if (out_data_i.last !== e.last)
            report("last", 64'(out_data_i.last), 64'(e.last));
        end
      end
      if (in_valid_i && in_ready_i) apply_item(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_DIST: lo_dist  <= cfg_data_i;
          REG_MAX_DIST: hi_dist  <= cfg_data_i;
          REG_BINS:     bins_reg <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb_binned_mean_stddev_histogram_unit.sv
// ----------------------------------------------------------------------------
// tb_binned_mean_stddev_histogram_unit
// Drives sample and dump transactions through a series of range and bin
// settings, with random gaps and output stalls; a checker predicts and
// compares every bin report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binned_mean_stddev_histogram_unit;
  import bmsh_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_MIN_DIST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    err_count, pending, reports_seen;
  bit                    calm = 1'b0;
  int                    n_adds, n_dumps, n_settings;

  always #5 clk_i = ~clk_i;

  binned_mean_stddev_histogram_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  bmsh_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .reports_seen_o (reports_seen)
  );

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    if (it.action == ACT_DUMP) n_dumps++;
    else n_adds++;
  endtask

  // adds leave no report behind, so allow an add's latency after draining
  task automatic drain_store();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_ranges(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] nb);
    cfg_we <= 1'b1; cfg_idx <= REG_MIN_DIST; cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx <= REG_MAX_DIST; cfg_data <= hi;
    @(posedge clk_i);
    cfg_idx <= REG_BINS; cfg_data <= nb;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic in_item_t make_add(input logic [15:0] d, input logic [15:0] v);
    in_item_t it;
    it.action       = ACT_ADD;
    it.distance     = d;
    it.sample_value = v;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic [15:0] lo, input logic [15:0] hi,
                                         input int dump_pct);
    in_item_t it;
    int       sel;
    it  = make_add(16'($urandom), 16'($urandom));
    sel = $urandom_range(99);
    if (sel < 8) begin
      it.sample_value = sel[0] ? 16'sh7FFF : 16'sh8000;
    end
    if ($urandom_range(99) < dump_pct) begin
      it.action = ACT_DUMP;
    end else if (lo < hi) begin
      sel = $urandom_range(99);
      if (sel < 70)      it.distance = 16'($urandom_range(hi, lo));
      else if (sel < 80) it.distance = sel[0] ? lo : hi;
    end
    return it;
  endfunction

  typedef struct {
    logic [15:0] lo, hi, nb;
    int          count, dump_pct;
    bit          quiet, hold;
  } phase_t;

  phase_t phases[9] = '{
    '{16'h0100, 16'h2000, 16'd8,   70, 6, 1'b0, 1'b0},
    '{16'h0000, 16'h0001, 16'd0,   40, 6, 1'b0, 1'b0},
    '{16'h1234, 16'h1240, 16'd100, 30, 0, 1'b0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 16'd5,   25, 6, 1'b0, 1'b0},
    '{16'h8000, 16'h4000, 16'd3,   25, 6, 1'b0, 1'b0},
    '{16'h0000, 16'hFFFF, 16'd2,   70, 6, 1'b1, 1'b0},
    '{16'h7FFF, 16'hFFFE, 16'd16,  80, 4, 1'b0, 1'b1},
    '{16'h0010, 16'h0020, 16'd64,  40, 0, 1'b0, 1'b0},
    '{16'h0000, 16'h0100, 16'd4,   90, 6, 1'b0, 1'b0}
  };

  initial begin
    in_item_t dump_it;
    dump_it = '0;
    dump_it.action = ACT_DUMP;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes under the reset settings, then every bin reported
    send_item(make_add(16'h0000, 16'h8000));
    send_item(make_add(16'hFFFF, 16'h7FFF));
    send_item(make_add(16'hFFFF, 16'h8000));
    send_item(make_add(16'h8000, 16'h0000));
    send_item(make_add(16'h8000, 16'h7FFF));
    send_item(make_add(16'h8000, 16'h7FFF));
    send_item(make_add(16'h03FF, 16'hFFFF));
    send_item(dump_it);

    foreach (phases[p]) begin
      drain_store();
      calm = phases[p].quiet;
      set_ranges(phases[p].lo, phases[p].hi, phases[p].nb);
      for (int k = 0; k < phases[p].count; k++) begin
        if (phases[p].hold && k == phases[p].count / 2) drain_store();
        send_item(rand_item(phases[p].lo, phases[p].hi, phases[p].dump_pct));
      end
      send_item(dump_it);
    end
    calm = 1'b0;
    drain_store();
    repeat (300) @(posedge clk_i);

    $display("Covered %0d adds and %0d dumps over %0d register settings,",
             n_adds, n_dumps, n_settings + 1);
    $display("with %0d bin reports compared.", reports_seen);
    if (err_count == 0) begin
      $display("tb_binned_mean_stddev_histogram_unit: PASS");
    end else begin
      $display("tb_binned_mean_stddev_histogram_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("Timeout with %0d bin reports still outstanding", pending);
    $display("tb_binned_mean_stddev_histogram_unit: FAIL");
    $finish;
  end

endmodule
